// ===== sv/ccls_pkg.sv =====
package ccls_pkg;

  localparam int LOG_DEPTH = 64;
  localparam int PTR_W     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
  localparam int CFG_IDX_W = 1;

  // request types
  localparam logic [1:0] REQ_APPEND  = 2'd0;
  localparam logic [1:0] REQ_GET_LOG = 2'd1;
  localparam logic [1:0] REQ_QUERY   = 2'd2;

  // log selectors
  localparam logic [1:0] SEL_CEL = 2'd0;
  localparam logic [1:0] SEL_VDL = 2'd1;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_LEN   = 2'd1;
  localparam logic [1:0] ST_BAD_INPUT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LOG_EFFECT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LOGS_EFFECT = 1'd1;

  localparam logic [11:0] GETLOG_LEN       = 12'd24;
  localparam logic [8:0]  QUERY_RESP_BYTES = 9'd48;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  log_sel;
    logic [15:0] opcode;
    logic [7:0]  effect;
    logic [11:0] payload_len;
    logic [7:0]  start_entry;
    logic [7:0]  entry_count;
  } ccls_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] entry_data;
    logic        data_valid;
    logic        last;
    logic [8:0]  cel_bytes;
    logic [8:0]  vdl_bytes;
    logic [8:0]  resp_len;
  } ccls_out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic stream_load;
    logic issue;
    logic push_single;
    logic append;
    logic log_read;
    logic log_query;
  } ccls_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic stream_ok;
    logic getlog_ok;
    logic append_ok;
    logic query_ok;
    logic can_push;
    logic can_issue;
    logic last_issue;
  } ccls_sts_t;

endpackage

// ===== sv/ccls_ctrl.sv =====
module ccls_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ccls_pkg::ccls_sts_t sts,
  output ccls_pkg::ccls_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_STREAM = 4'b0100,
    S_LOG    = 4'b1000
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.stream_ok) begin
          cmd.stream_load = 1'b1;
          state_nxt       = S_STREAM;
        end else if (sts.can_push) begin
          // single-result request: respond and update the logs together
          cmd.push_single = 1'b1;
          cmd.append      = sts.append_ok;
          cmd.log_read    = sts.getlog_ok;
          cmd.log_query   = sts.query_ok;
          state_nxt       = S_IDLE;
        end
      end
      S_STREAM: begin
        if (sts.can_issue) begin
          cmd.issue = 1'b1;
          if (sts.last_issue) begin
            state_nxt = S_LOG;
          end
        end
      end
      S_LOG: begin
        cmd.log_read = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/ccls_dp.sv =====
module ccls_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ccls_pkg::ccls_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ccls_pkg::ccls_out_t                 out_data,
  input  logic                                cfg_valid,
  input  logic [ccls_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                          cfg_data,
  input  ccls_pkg::ccls_cmd_t                 cmd,
  output ccls_pkg::ccls_sts_t                 sts
);

  localparam int PW = ccls_pkg::PTR_W;
  localparam int CW = ccls_pkg::CNT_W;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(ccls_pkg::LOG_DEPTH - 1)) ? '0 : (p + PW'(1));
  endfunction

  logic [31:0] cel_mem [ccls_pkg::LOG_DEPTH];
  logic [31:0] vdl_mem [ccls_pkg::LOG_DEPTH];

  logic [7:0]          read_log_effect_r;
  logic [7:0]          query_logs_effect_r;
  ccls_pkg::ccls_in_t  req_r;

  logic [PW-1:0] cel_wr_ptr_r, cel_oldest_r, vdl_wr_ptr_r, vdl_oldest_r;
  logic [CW-1:0] cel_count_r, vdl_count_r;

  logic [PW-1:0] rd_ptr_r;
  logic [7:0]    rem_r;
  logic          inflight_r;
  logic          rd_last_r;
  logic [31:0]   rd_data_r;
  logic [8:0]    stream_len_r;

  ccls_pkg::ccls_out_t q_r [2];
  logic [1:0]          q_cnt_r;

  // ---------------- request decode ----------------
  logic          sel_ok, is_vdl, len24, win_ok, getlog_ok, query_ok, append_ok;
  logic [CW-1:0] sel_cnt;
  logic [PW-1:0] sel_old;
  logic [8:0]    base_sum;
  logic [1:0]    single_st;
  ccls_pkg::ccls_out_t single_res, read_res, push_res;

  assign is_vdl  = (req_r.log_sel == ccls_pkg::SEL_VDL);
  assign sel_ok  = (req_r.log_sel == ccls_pkg::SEL_CEL) || is_vdl;
  assign sel_cnt = is_vdl ? vdl_count_r : cel_count_r;
  assign sel_old = is_vdl ? vdl_oldest_r : cel_oldest_r;
  assign len24   = (req_r.payload_len == ccls_pkg::GETLOG_LEN);
  assign win_ok  = ({1'b0, req_r.start_entry} < 9'(sel_cnt)) &&
                   (({1'b0, req_r.start_entry} + {1'b0, req_r.entry_count}) <= 9'(sel_cnt));

  assign getlog_ok = (req_r.req_type == ccls_pkg::REQ_GET_LOG) && len24 && sel_ok && win_ok;
  assign query_ok  = (req_r.req_type == ccls_pkg::REQ_QUERY) && (req_r.payload_len == '0);
  assign append_ok = (req_r.req_type == ccls_pkg::REQ_APPEND) && sel_ok;

  // window start never exceeds twice the depth, one subtract wraps it
  assign base_sum = 9'(sel_old) + {1'b0, req_r.start_entry};

  always_comb begin
    case (req_r.req_type)
      ccls_pkg::REQ_APPEND: begin
        single_st = sel_ok ? ccls_pkg::ST_OK : ccls_pkg::ST_BAD_INPUT;
      end
      ccls_pkg::REQ_GET_LOG: begin
        if (!len24) begin
          single_st = ccls_pkg::ST_BAD_LEN;
        end else if (!sel_ok || !win_ok) begin
          single_st = ccls_pkg::ST_BAD_INPUT;
        end else begin
          single_st = ccls_pkg::ST_OK;
        end
      end
      ccls_pkg::REQ_QUERY: begin
        single_st = query_ok ? ccls_pkg::ST_OK : ccls_pkg::ST_BAD_LEN;
      end
      default: begin
        single_st = ccls_pkg::ST_BAD_INPUT;
      end
    endcase
  end

  always_comb begin
    single_res        = '0;
    single_res.status = single_st;
    single_res.last   = 1'b1;
    if (query_ok) begin
      single_res.cel_bytes = 9'({cel_count_r, 2'b00});
      single_res.vdl_bytes = 9'({vdl_count_r, 2'b00});
      single_res.resp_len  = ccls_pkg::QUERY_RESP_BYTES;
    end
  end

  always_comb begin
    read_res            = '0;
    read_res.status     = ccls_pkg::ST_OK;
    read_res.entry_data = rd_data_r;
    read_res.data_valid = 1'b1;
    read_res.last       = rd_last_r;
    read_res.resp_len   = stream_len_r;
  end

  // ---------------- output queue (two entries) ----------------
  logic       pop, push;
  logic [2:0] occ_after;

  assign out_valid = (q_cnt_r != 2'd0);
  assign out_data  = q_r[0];
  assign pop       = out_valid && !out_stall;
  assign push      = cmd.push_single || inflight_r;
  assign push_res  = inflight_r ? read_res : single_res;
  assign occ_after = 3'(q_cnt_r) + 3'(inflight_r) - 3'(pop);

  assign sts.stream_ok  = getlog_ok && (req_r.entry_count != 8'd0);
  assign sts.getlog_ok  = getlog_ok;
  assign sts.append_ok  = append_ok;
  assign sts.query_ok   = query_ok;
  assign sts.can_push   = !inflight_r && (occ_after < 3'd2);
  assign sts.can_issue  = (occ_after < 3'd2);
  assign sts.last_issue = (rem_r == 8'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else begin
      if (push && !pop) begin
        q_cnt_r <= q_cnt_r + 2'd1;
      end else if (pop && !push) begin
        q_cnt_r <= q_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q_r[0] <= q_r[1];
    end
    if (push) begin
      if ((q_cnt_r == 2'd0) || (q_cnt_r == 2'd1 && pop)) begin
        q_r[0] <= push_res;
      end else begin
        q_r[1] <= push_res;
      end
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_log_effect_r   <= 8'd0;
      query_logs_effect_r <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ccls_pkg::CFG_READ_LOG_EFFECT:   read_log_effect_r   <= cfg_data;
        ccls_pkg::CFG_QUERY_LOGS_EFFECT: query_logs_effect_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
  end

  // ---------------- log writes ----------------
  logic        cel_we, vdl_we;
  logic [31:0] cel_wdata, vdl_wdata;
  logic [7:0]  vdl_eff;

  assign cel_we    = cmd.append && !is_vdl;
  assign vdl_we    = (cmd.append && is_vdl) || cmd.log_read || cmd.log_query;
  assign cel_wdata = {8'h00, req_r.effect, req_r.opcode};
  always_comb begin
    if (cmd.log_read) begin
      vdl_eff = read_log_effect_r;
    end else if (cmd.log_query) begin
      vdl_eff = query_logs_effect_r;
    end else begin
      vdl_eff = req_r.effect;
    end
  end
  assign vdl_wdata = {8'h00, vdl_eff, req_r.opcode};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cel_wr_ptr_r <= '0;
      cel_oldest_r <= '0;
      cel_count_r  <= '0;
      vdl_wr_ptr_r <= '0;
      vdl_oldest_r <= '0;
      vdl_count_r  <= '0;
    end else begin
      if (cel_we) begin
        cel_wr_ptr_r <= ptr_inc(cel_wr_ptr_r);
        if (cel_count_r == CW'(ccls_pkg::LOG_DEPTH)) begin
          cel_oldest_r <= ptr_inc(cel_oldest_r);
        end else begin
          cel_count_r <= cel_count_r + CW'(1);
        end
      end
      if (vdl_we) begin
        vdl_wr_ptr_r <= ptr_inc(vdl_wr_ptr_r);
        if (vdl_count_r == CW'(ccls_pkg::LOG_DEPTH)) begin
          vdl_oldest_r <= ptr_inc(vdl_oldest_r);
        end else begin
          vdl_count_r <= vdl_count_r + CW'(1);
        end
      end
    end
  end

  // ---------------- log memories ----------------
  always_ff @(posedge clk) begin
    if (cel_we) begin
      cel_mem[cel_wr_ptr_r] <= cel_wdata;
    end
    if (vdl_we) begin
      vdl_mem[vdl_wr_ptr_r] <= vdl_wdata;
    end
    if (cmd.issue) begin
      rd_data_r <= is_vdl ? vdl_mem[rd_ptr_r] : cel_mem[rd_ptr_r];
    end
  end

  // ---------------- read walker ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 1'b0;
    end else begin
      inflight_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stream_load) begin
      rd_ptr_r     <= (base_sum >= 9'(ccls_pkg::LOG_DEPTH))
                      ? PW'(base_sum - 9'(ccls_pkg::LOG_DEPTH)) : PW'(base_sum);
      rem_r        <= req_r.entry_count;
      stream_len_r <= 9'({1'b0, req_r.entry_count} << 2);
    end else if (cmd.issue) begin
      rd_ptr_r <= ptr_inc(rd_ptr_r);
      rem_r    <= rem_r - 8'd1;
    end
    if (cmd.issue) begin
      rd_last_r <= (rem_r == 8'd1);
    end
  end

endmodule

// ===== sv/circular_command_log_store_top.sv =====
// Append, query, error and empty-window requests: one result, pushed into the
// output queue from the decode state; the next item is taken back in the idle state.
// Get-log of N entries (N at most 64, the log depth): one entry per cycle from the
// log memory read port while the two-entry output queue has room.
// Output stalls that fill the two-entry queue hold the flow. Synchronous active-low reset
// clears pointers, counts, config and queue; log memory stays undefined until written.
module circular_command_log_store_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ccls_pkg::ccls_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ccls_pkg::ccls_out_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ccls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  ccls_pkg::ccls_cmd_t cmd;
  ccls_pkg::ccls_sts_t sts;

  assign cfg_ready = 1'b1;

  ccls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ccls_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== sv/ccls_checker.sv =====
module ccls_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input ccls_pkg::ccls_out_t            out_data
);

  // one item at a time: stall rises right after an item is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous one in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.data_valid |-> out_data.entry_data == 32'd0)
    else $error("entry_data set without data_valid");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ccls_pkg::ST_OK |-> out_data.last && !out_data.data_valid)
    else $error("error result not a single final item");

endmodule

bind circular_command_log_store_top ccls_checker u_ccls_checker (.*);
